// File: hdl/bwt_pkg.sv
// Shared types and constants for the breakpoint / watchpoint table.
// No dependencies; bwt_match, the top and the testbench import this package.
package bwt_pkg;

    // Field widths of one item and one result
    localparam int CMD_W  = 3;
    localparam int ADDR_W = 32;
    localparam int LEN_W  = 32;
    localparam int KIND_W = 4;
    localparam int STAT_W = 2;

    // Breakpoint table word: {kind, address}
    localparam int BK_W = KIND_W + ADDR_W;

    // Watchpoint table word: {kind, length, start}
    localparam int WT_W       = KIND_W + LEN_W + ADDR_W;
    localparam int WT_LEN_LO  = ADDR_W;
    localparam int WT_KIND_LO = ADDR_W + LEN_W;

    // Command codes (code 7 is unused and acts as a no-op)
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_BKPT  = 3'd0,
        CMD_DEL_BKPT  = 3'd1,
        CMD_ADD_WATCH = 3'd2,
        CMD_DEL_WATCH = 3'd3,
        CMD_CLEAR_ALL = 3'd4,
        CMD_CHK_BKPT  = 3'd5,
        CMD_CHK_WATCH = 3'd6
    } t_cmd;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_HIT   = 2'd1,
        ST_NOHIT = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_FIN  = 2'd2
    } t_state;

    // Per-entry compare results for the entry under scan
    typedef struct packed {
        logic bk_eq;   // used breakpoint at the same even address
        logic wt_eq;   // used watchpoint with same start and kind
        logic wt_hit;  // used watchpoint of same kind that covers the address
    } t_match;

endpackage

// File: hdl/bwt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bwt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/bwt_match.sv
// Compare logic for one table entry read from RAM against the current item.
// Depends on bwt_pkg for field widths, word layouts and t_match.
module bwt_match (
    input  logic [bwt_pkg::ADDR_W-1:0] i_addr,
    input  logic [bwt_pkg::KIND_W-1:0] i_kind,
    input  logic                       i_bk_used,
    input  logic [bwt_pkg::BK_W-1:0]   i_bk_word,
    input  logic                       i_wt_used,
    input  logic [bwt_pkg::WT_W-1:0]   i_wt_word,
    output bwt_pkg::t_match            o_match
);
    import bwt_pkg::*;

    logic [ADDR_W-1:0] baddr;
    logic [ADDR_W-1:0] wt_start;
    logic [LEN_W-1:0]  wt_len;
    logic [KIND_W-1:0] wt_kind;
    logic [ADDR_W-1:0] wt_end;
    logic              kind_eq;

    // Breakpoints compare on the even address
    assign baddr = {i_addr[ADDR_W-1:1], 1'b0};

    // Split the watchpoint word
    assign wt_start = i_wt_word[ADDR_W-1:0];
    assign wt_len   = i_wt_word[WT_LEN_LO +: LEN_W];
    assign wt_kind  = i_wt_word[WT_KIND_LO +: KIND_W];

    // End of the covered range, wrapping at 2^32
    assign wt_end  = wt_start + wt_len;
    assign kind_eq = (wt_kind == i_kind);

    always_comb begin
        o_match.bk_eq  = i_bk_used && (i_bk_word[ADDR_W-1:0] == baddr);
        o_match.wt_eq  = i_wt_used && kind_eq && (wt_start == i_addr);
        o_match.wt_hit = i_wt_used && kind_eq && (i_addr >= wt_start) && (i_addr < wt_end);
    end

endmodule

// File: hdl/breakpoint_watchpoint_table_top.sv
// Breakpoint / watchpoint table: sequencer, used bits and the two table RAMs.
// Depends on bwt_pkg, bwt_ram and bwt_match.
//
//  Channel  Direction  Handshake           Payload
//  -------  ---------  ------------------  ------------------------------
//  command  in         i_valid / o_stall   i_cmd, i_addr, i_len, i_kind
//  result   out        o_valid / i_stall   o_status, o_hit_addr
//
// Breakpoint and watch commands read the table RAM once per entry, drain the
// read and compare pipeline, then take a write-back step and an idle step
// before the next item; clear-all and the unused code go straight to
// write-back and idle.
// Used bits sit in flops and clear on reset; table RAMs need no clearing pass.
// A finished result waits in the output register; only the write-back cycle
// waits for it to drain while i_stall is high.
module breakpoint_watchpoint_table_top #(
    parameter int BKPT_SLOTS  = 16,
    parameter int WATCH_SLOTS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [bwt_pkg::CMD_W-1:0]  i_cmd,
    input  logic [bwt_pkg::ADDR_W-1:0] i_addr,
    input  logic [bwt_pkg::LEN_W-1:0]  i_len,
    input  logic [bwt_pkg::KIND_W-1:0] i_kind,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [bwt_pkg::STAT_W-1:0] o_status,
    output logic [bwt_pkg::ADDR_W-1:0] o_hit_addr
);
    import bwt_pkg::*;

    localparam int BIW  = (BKPT_SLOTS > 1) ? $clog2(BKPT_SLOTS) : 1;
    localparam int WIW  = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;
    localparam int IW   = (BIW > WIW) ? BIW : WIW;
    localparam int MAXS = (BKPT_SLOTS > WATCH_SLOTS) ? BKPT_SLOTS : WATCH_SLOTS;
    localparam int PW   = $clog2(MAXS + 1);

    // Control registers
    t_state                 r_state, n_state;
    logic [BKPT_SLOTS-1:0]  r_bk_used;
    logic [WATCH_SLOTS-1:0] r_wt_used;
    logic                   r_out_vld;

    // Item and scan registers
    logic [CMD_W-1:0]  r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_len;
    logic [KIND_W-1:0] r_kind;
    logic [PW-1:0]     r_ptr;
    logic [PW-1:0]     r_lim;
    logic              r_cmp_vld;
    logic [IW-1:0]     r_cmp_idx;
    logic              r_found;
    logic [IW-1:0]     r_fidx;
    logic [LEN_W-1:0]  r_fsize;
    logic              r_free_vld;
    logic [IW-1:0]     r_free_idx;
    logic [STAT_W-1:0] r_out_status;
    logic [ADDR_W-1:0] r_out_hit;

    // Datapath signals
    logic              acc;
    logic              in_bk;
    logic              in_wt;
    logic              cmd_bk;
    logic              fin_go;
    logic              scan_end;
    logic [ADDR_W-1:0] baddr;
    logic              cmp_used;
    logic              cmp_cond;
    logic [BK_W-1:0]   bk_rdata;
    logic [WT_W-1:0]   wt_rdata;
    t_match            match;
    logic              bk_we;
    logic [BK_W-1:0]   bk_wdata;
    logic              wt_we;
    logic [WIW-1:0]    wt_waddr;
    logic [WT_W-1:0]   wt_wdata;
    logic [LEN_W-1:0]  wt_new_len;
    logic [STAT_W-1:0] n_out_status;
    logic [ADDR_W-1:0] n_out_hit;

    assign acc     = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_vld;
    assign o_status   = r_out_status;
    assign o_hit_addr = r_out_hit;

    assign in_bk  = i_cmd inside {CMD_ADD_BKPT, CMD_DEL_BKPT, CMD_CHK_BKPT};
    assign in_wt  = i_cmd inside {CMD_ADD_WATCH, CMD_DEL_WATCH, CMD_CHK_WATCH};
    assign cmd_bk = r_cmd inside {CMD_ADD_BKPT, CMD_DEL_BKPT, CMD_CHK_BKPT};
    assign baddr  = {r_addr[ADDR_W-1:1], 1'b0};

    assign scan_end = (r_ptr == r_lim) && !r_cmp_vld;
    assign fin_go   = (r_state == S_FIN) && !(r_out_vld && i_stall);

    // Table RAMs
    bwt_ram #(.WIDTH(BK_W), .DEPTH(BKPT_SLOTS), .AW(BIW)) u_bk_ram (
        .i_clk   (i_clk),
        .i_we    (bk_we),
        .i_waddr (r_free_idx[BIW-1:0]),
        .i_wdata (bk_wdata),
        .i_raddr (r_ptr[BIW-1:0]),
        .o_rdata (bk_rdata)
    );

    bwt_ram #(.WIDTH(WT_W), .DEPTH(WATCH_SLOTS), .AW(WIW)) u_wt_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (wt_waddr),
        .i_wdata (wt_wdata),
        .i_raddr (r_ptr[WIW-1:0]),
        .o_rdata (wt_rdata)
    );

    // Compare the entry read last cycle
    bwt_match u_match (
        .i_addr    (r_addr),
        .i_kind    (r_kind),
        .i_bk_used (r_bk_used[r_cmp_idx[BIW-1:0]]),
        .i_bk_word (bk_rdata),
        .i_wt_used (r_wt_used[r_cmp_idx[WIW-1:0]]),
        .i_wt_word (wt_rdata),
        .o_match   (match)
    );

    // Pick the compare and used bit for the table being scanned
    always_comb begin
        if (cmd_bk) begin
            cmp_used = r_bk_used[r_cmp_idx[BIW-1:0]];
            cmp_cond = match.bk_eq;
        end else begin
            cmp_used = r_wt_used[r_cmp_idx[WIW-1:0]];
            cmp_cond = (r_cmd == CMD_CHK_WATCH) ? match.wt_hit : match.wt_eq;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_state = (in_bk || in_wt) ? S_SCAN : S_FIN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Write-back and result of the finishing item
    always_comb begin
        wt_new_len = (r_found && (r_fsize > r_len)) ? r_fsize : r_len;
        bk_wdata   = {r_kind, baddr};
        wt_wdata   = {r_kind, wt_new_len, r_addr};
        wt_waddr   = r_found ? r_fidx[WIW-1:0] : r_free_idx[WIW-1:0];
        bk_we      = 1'b0;
        wt_we      = 1'b0;
        n_out_status = ST_DONE;
        n_out_hit    = '0;
        case (r_cmd)
            CMD_ADD_BKPT: begin
                bk_we = fin_go && !r_found && r_free_vld;
                if (!r_found && !r_free_vld) begin
                    n_out_status = ST_FULL;
                end
            end
            CMD_ADD_WATCH: begin
                wt_we = fin_go && (r_found || r_free_vld);
                if (!r_found && !r_free_vld) begin
                    n_out_status = ST_FULL;
                end
            end
            CMD_CHK_BKPT: begin
                n_out_status = r_found ? ST_HIT : ST_NOHIT;
                n_out_hit    = r_found ? baddr : '0;
            end
            CMD_CHK_WATCH: begin
                n_out_status = r_found ? ST_HIT : ST_NOHIT;
                n_out_hit    = r_found ? r_addr : '0;
            end
            default: n_out_status = ST_DONE;
        endcase
    end

    // Control state: sequencer, used bits, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bk_used <= '0;
            r_wt_used <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_go) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end
            if (fin_go) begin
                case (r_cmd)
                    CMD_ADD_BKPT: begin
                        if (bk_we) begin
                            r_bk_used[r_free_idx[BIW-1:0]] <= 1'b1;
                        end
                    end
                    CMD_DEL_BKPT: begin
                        if (r_found) begin
                            r_bk_used[r_fidx[BIW-1:0]] <= 1'b0;
                        end
                    end
                    CMD_ADD_WATCH: begin
                        if (wt_we) begin
                            r_wt_used[wt_waddr] <= 1'b1;
                        end
                    end
                    CMD_DEL_WATCH: begin
                        if (r_found) begin
                            r_wt_used[r_fidx[WIW-1:0]] <= 1'b0;
                        end
                    end
                    CMD_CLEAR_ALL: begin
                        r_bk_used <= '0;
                        r_wt_used <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Item capture, table scan and result register
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_cmd      <= i_cmd;
            r_addr     <= i_addr;
            r_len      <= i_len;
            r_kind     <= i_kind;
            r_ptr      <= '0;
            r_lim      <= in_bk ? PW'(BKPT_SLOTS) : PW'(WATCH_SLOTS);
            r_cmp_vld  <= 1'b0;
            r_found    <= 1'b0;
            r_free_vld <= 1'b0;
        end else if (r_state == S_SCAN) begin
            // Issue the next read, compare the one that came back
            r_cmp_vld <= (r_ptr != r_lim);
            r_cmp_idx <= r_ptr[IW-1:0];
            if (r_ptr != r_lim) begin
                r_ptr <= r_ptr + PW'(1);
            end
            if (r_cmp_vld) begin
                if (cmp_cond && !r_found) begin
                    r_found <= 1'b1;
                    r_fidx  <= r_cmp_idx;
                    r_fsize <= wt_rdata[WT_LEN_LO +: LEN_W];
                end
                if (!cmp_used && !r_free_vld) begin
                    r_free_vld <= 1'b1;
                    r_free_idx <= r_cmp_idx;
                end
            end
        end
        if (fin_go) begin
            r_out_status <= n_out_status;
            r_out_hit    <= n_out_hit;
        end
    end

`ifndef NO_ASSERTIONS
    // A new result only comes from the write-back cycle
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state) == S_FIN)
        else $error("result valid rose outside write-back");

    // The scan pointer never runs past the table size
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_ptr <= r_lim)
        else $error("scan pointer past table end");

    // A result held under stall keeps the next one in write-back
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_out_vld && i_stall) |=> r_state == S_FIN)
        else $error("write-back left while result was stalled");

    // A new breakpoint only lands in a free slot
    a_bk_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bk_we |-> !r_bk_used[r_free_idx[BIW-1:0]])
        else $error("breakpoint written over a used slot");
`endif

endmodule

// File: tb/tb_breakpoint_watchpoint_table_top.sv
// Testbench for breakpoint_watchpoint_table_top: directed and random command items,
// checked one by one against a behavioral copy of both tables.
// Depends on bwt_pkg and the RTL of breakpoint_watchpoint_table_top.
module tb_breakpoint_watchpoint_table_top;
    import bwt_pkg::*;

    localparam int BK_N = 16;
    localparam int WT_N = 8;
    localparam int BK_POOL_N = 20;
    localparam int WT_POOL_N = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam logic [CMD_W-1:0] CMD_NOOP = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] addr;
        logic [LEN_W-1:0]  len;
        logic [KIND_W-1:0] kind;
    } t_dbg_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] hit_addr;
    } t_dbg_result;

    typedef enum int {
        STALL_OFF,
        STALL_RANDOM,
        STALL_PATTERN
    } t_stall_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [CMD_W-1:0]   i_cmd = '0;
    logic [ADDR_W-1:0]  i_addr = '0;
    logic [LEN_W-1:0]   i_len = '0;
    logic [KIND_W-1:0]  i_kind = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [STAT_W-1:0]  o_status;
    logic [ADDR_W-1:0]  o_hit_addr;

    // Shadow copy of both tables
    bit                bkpt_live [BK_N];
    bit [ADDR_W-1:0]   bkpt_addr [BK_N];
    bit [KIND_W-1:0]   bkpt_kind [BK_N];
    bit                watch_live [WT_N];
    bit [ADDR_W-1:0]   watch_base [WT_N];
    bit [LEN_W-1:0]    watch_len [WT_N];
    bit [KIND_W-1:0]   watch_kind [WT_N];

    // Address pools that make random items collide with table entries
    bit [ADDR_W-1:0]   bkpt_pool [BK_POOL_N];
    bit [ADDR_W-1:0]   watch_pool [WT_POOL_N];

    t_dbg_result       pending_results [$];
    t_dbg_result       oldest_result;
    int                fail_count = 0;
    int                cycle_count = 0;
    int                hold_req = 0;
    int                hold_left = 0;
    int                mode_left = 0;
    t_stall_mode       stall_mode = STALL_OFF;
    logic [7:0]        stall_pat = 8'h00;

    breakpoint_watchpoint_table_top #(
        .BKPT_SLOTS  (BK_N),
        .WATCH_SLOTS (WT_N)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_cmd      (i_cmd),
        .i_addr     (i_addr),
        .i_len      (i_len),
        .i_kind     (i_kind),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_hit_addr (o_hit_addr)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Find a used breakpoint at an even address
    function automatic int bkpt_slot_of(input bit [ADDR_W-1:0] even_addr);
        for (int i = 0; i < BK_N; i++) begin
            if (bkpt_live[i] && bkpt_addr[i] == even_addr) return i;
        end
        return -1;
    endfunction

    // Find a used watchpoint with the same start and kind
    function automatic int watch_slot_of(input bit [ADDR_W-1:0] start,
                                         input bit [KIND_W-1:0] kind);
        for (int i = 0; i < WT_N; i++) begin
            if (watch_live[i] && watch_base[i] == start && watch_kind[i] == kind) return i;
        end
        return -1;
    endfunction

    // Apply one command to the shadow tables and return the result it gives
    function automatic t_dbg_result table_response(input t_dbg_item it);
        t_dbg_result       r;
        bit [ADDR_W-1:0]   even_addr;
        bit [ADDR_W-1:0]   span_end;
        int                slot;
        r.status = ST_DONE;
        r.hit_addr = '0;
        even_addr = {it.addr[ADDR_W-1:1], 1'b0};
        slot = -1;
        case (it.cmd)
            CMD_ADD_BKPT: begin
                if (bkpt_slot_of(even_addr) < 0) begin
                    for (int i = BK_N - 1; i >= 0; i--) begin
                        if (!bkpt_live[i]) slot = i;
                    end
                    if (slot < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        bkpt_live[slot] = 1'b1;
                        bkpt_addr[slot] = even_addr;
                        bkpt_kind[slot] = it.kind;
                    end
                end
            end
            CMD_DEL_BKPT: begin
                slot = bkpt_slot_of(even_addr);
                if (slot >= 0) bkpt_live[slot] = 1'b0;
            end
            CMD_ADD_WATCH: begin
                slot = watch_slot_of(it.addr, it.kind);
                if (slot >= 0) begin
                    // widen only, never shrink
                    if (watch_len[slot] < it.len) watch_len[slot] = it.len;
                end else begin
                    for (int i = WT_N - 1; i >= 0; i--) begin
                        if (!watch_live[i]) slot = i;
                    end
                    if (slot < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        watch_live[slot] = 1'b1;
                        watch_base[slot] = it.addr;
                        watch_len[slot] = it.len;
                        watch_kind[slot] = it.kind;
                    end
                end
            end
            CMD_DEL_WATCH: begin
                slot = watch_slot_of(it.addr, it.kind);
                if (slot >= 0) watch_live[slot] = 1'b0;
            end
            CMD_CLEAR_ALL: begin
                foreach (bkpt_live[i]) bkpt_live[i] = 1'b0;
                foreach (watch_live[i]) watch_live[i] = 1'b0;
            end
            CMD_CHK_BKPT: begin
                if (bkpt_slot_of(even_addr) >= 0) begin
                    r.status = ST_HIT;
                    r.hit_addr = even_addr;
                end else begin
                    r.status = ST_NOHIT;
                end
            end
            CMD_CHK_WATCH: begin
                r.status = ST_NOHIT;
                for (int i = 0; i < WT_N; i++) begin
                    // end of range wraps at 2^32; a wrapped range never hits
                    span_end = watch_base[i] + watch_len[i];
                    if (watch_live[i] && watch_kind[i] == it.kind &&
                        it.addr >= watch_base[i] && it.addr < span_end) begin
                        r.status = ST_HIT;
                        r.hit_addr = it.addr;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Build one random item, mostly aimed at addresses already in the tables
    function automatic t_dbg_item random_item();
        t_dbg_item it;
        int        pick;
        it.addr = $urandom;
        it.len = $urandom;
        it.kind = KIND_W'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            it.cmd = CMD_ADD_BKPT;
            if ($urandom_range(0, 9) != 0)
                it.addr = bkpt_pool[$urandom_range(0, BK_POOL_N - 1)] | $urandom_range(0, 1);
        end else if (pick < 28) begin
            it.cmd = CMD_DEL_BKPT;
            it.addr = bkpt_pool[$urandom_range(0, BK_POOL_N - 1)] | $urandom_range(0, 1);
        end else if (pick < 44) begin
            it.cmd = CMD_ADD_WATCH;
            it.kind = KIND_W'($urandom_range(0, 3));
            if ($urandom_range(0, 7) != 0) begin
                it.addr = watch_pool[$urandom_range(0, WT_POOL_N - 1)];
                it.len = $urandom_range(0, 64);
            end
        end else if (pick < 51) begin
            it.cmd = CMD_DEL_WATCH;
            it.kind = KIND_W'($urandom_range(0, 3));
            it.addr = watch_pool[$urandom_range(0, WT_POOL_N - 1)];
        end else if (pick < 52) begin
            it.cmd = CMD_CLEAR_ALL;
        end else if (pick < 72) begin
            it.cmd = CMD_CHK_BKPT;
            if ($urandom_range(0, 7) != 0)
                it.addr = bkpt_pool[$urandom_range(0, BK_POOL_N - 1)] | $urandom_range(0, 1);
        end else if (pick < 95) begin
            it.cmd = CMD_CHK_WATCH;
            it.kind = KIND_W'($urandom_range(0, 3));
            if ($urandom_range(0, 9) != 0)
                it.addr = watch_pool[$urandom_range(0, WT_POOL_N - 1)] +
                          $urandom_range(0, 80);
        end else begin
            it.cmd = CMD_NOOP;
        end
        return it;
    endfunction

    // Offer one item and hold it until accepted; valid stays high on return
    task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                                 input logic [LEN_W-1:0] len, input logic [KIND_W-1:0] kind);
        t_dbg_item   it;
        t_dbg_result exp_r;
        it = '{cmd: cmd, addr: addr, len: len, kind: kind};
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_addr <= addr;
        i_len <= len;
        i_kind <= kind;
        do @(posedge i_clk); while (o_stall);
        exp_r = table_response(it);
        pending_results = {pending_results, exp_r};
    endtask

    // Drop valid for a number of cycles
    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Field extremes, every command and the corner cases of both tables
    task automatic test_basic_commands();
        issue_command(CMD_CHK_BKPT, 32'h0000_0000, 32'h0, 4'h0);
        issue_command(CMD_ADD_BKPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
        issue_command(CMD_ADD_BKPT, 32'hFFFF_FFFE, 32'h0, 4'h0);
        issue_command(CMD_CHK_BKPT, 32'hFFFF_FFFF, 32'h0, 4'h0);
        issue_command(CMD_ADD_BKPT, 32'h0000_0000, 32'h0, 4'h0);
        issue_command(CMD_CHK_BKPT, 32'h0000_0001, 32'h0, 4'hF);
        issue_command(CMD_DEL_BKPT, 32'h0000_1234, 32'h0, 4'h0);
        issue_command(CMD_DEL_BKPT, 32'hFFFF_FFFF, 32'h0, 4'h0);
        issue_command(CMD_CHK_BKPT, 32'hFFFF_FFFE, 32'h0, 4'h0);
        issue_command(CMD_ADD_WATCH, 32'h0000_1000, 32'h0000_0010, 4'hA);
        issue_command(CMD_CHK_WATCH, 32'h0000_100F, 32'h0, 4'hA);
        issue_command(CMD_CHK_WATCH, 32'h0000_1010, 32'h0, 4'hA);
        issue_command(CMD_CHK_WATCH, 32'h0000_1000, 32'h0, 4'h5);
        // same start and kind: widen, then a shorter add must not shrink it
        issue_command(CMD_ADD_WATCH, 32'h0000_1000, 32'h0000_0020, 4'hA);
        issue_command(CMD_ADD_WATCH, 32'h0000_1000, 32'h0000_0004, 4'hA);
        issue_command(CMD_CHK_WATCH, 32'h0000_101F, 32'h0, 4'hA);
        // range that wraps past the top, and an empty range
        issue_command(CMD_ADD_WATCH, 32'hFFFF_FFF0, 32'h0000_0020, 4'h0);
        issue_command(CMD_CHK_WATCH, 32'hFFFF_FFF8, 32'h0, 4'h0);
        issue_command(CMD_ADD_WATCH, 32'h0000_0000, 32'h0000_0000, 4'h3);
        issue_command(CMD_CHK_WATCH, 32'h0000_0000, 32'h0, 4'h3);
        issue_command(CMD_ADD_WATCH, 32'h0000_0000, 32'hFFFF_FFFF, 4'hF);
        issue_command(CMD_CHK_WATCH, 32'hFFFF_FFFE, 32'h0, 4'hF);
        // delete with the wrong kind leaves the entry in place
        issue_command(CMD_DEL_WATCH, 32'h0000_1000, 32'hFFFF_FFFF, 4'h5);
        issue_command(CMD_DEL_WATCH, 32'h0000_1000, 32'h0, 4'hA);
        issue_command(CMD_CHK_WATCH, 32'h0000_1001, 32'h0, 4'hA);
        issue_command(CMD_NOOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
        issue_command(CMD_CLEAR_ALL, 32'h0, 32'h0, 4'h0);
        issue_command(CMD_CHK_WATCH, 32'hFFFF_FFFE, 32'h0, 4'hF);
        wait_drain();
    endtask

    // Fill both tables, overflow them, reuse a freed slot, widen while full
    task automatic test_table_full();
        logic [ADDR_W-1:0] bk_base;
        logic [ADDR_W-1:0] wt_base;
        bk_base = $urandom & 32'hFFFF_FFC0;
        wt_base = $urandom & 32'hFFFF_F000;
        for (int i = 0; i < BK_N; i++) begin
            pause_sender($urandom_range(0, 3));
            issue_command(CMD_ADD_BKPT, (bk_base + 2 * i) | $urandom_range(0, 1),
                          $urandom, KIND_W'($urandom_range(0, 15)));
        end
        issue_command(CMD_ADD_BKPT, bk_base + 2 * BK_N, 32'h0, 4'h0);
        issue_command(CMD_ADD_BKPT, bk_base + 1, 32'h0, 4'h0);
        issue_command(CMD_DEL_BKPT, bk_base + 10, 32'h0, 4'h0);
        issue_command(CMD_ADD_BKPT, bk_base + 2 * BK_N, 32'h0, 4'h0);
        issue_command(CMD_CHK_BKPT, bk_base + 2 * BK_N + 1, 32'h0, 4'h0);
        for (int i = 0; i < WT_N; i++) begin
            pause_sender($urandom_range(0, 3));
            issue_command(CMD_ADD_WATCH, wt_base + 64 * i, 32'd32, KIND_W'(i % 4));
        end
        issue_command(CMD_ADD_WATCH, wt_base + 64 * WT_N, 32'd32, 4'h0);
        issue_command(CMD_ADD_WATCH, wt_base, 32'd48, 4'h0);
        issue_command(CMD_CHK_WATCH, wt_base + 40, 32'h0, 4'h0);
        issue_command(CMD_CLEAR_ALL, 32'h0, 32'h0, 4'h0);
        wait_drain();
    endtask

    // Random items from the address pools, sent in bursts with gaps between
    task automatic test_random_mix(input int n_items);
        t_dbg_item it;
        int        burst_left;
        foreach (bkpt_pool[i]) bkpt_pool[i] = $urandom;
        foreach (watch_pool[i]) watch_pool[i] = $urandom;
        watch_pool[0] = 32'hFFFF_FFC0;
        burst_left = 0;
        for (int n = 0; n < n_items; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 24));
                else pause_sender($urandom_range(0, 2));
            end
            burst_left--;
            it = random_item();
            issue_command(it.cmd, it.addr, it.len, it.kind);
        end
        wait_drain();
    endtask

    // Receiver holds off while the sender keeps offering items back to back
    task automatic test_backpressure();
        t_dbg_item it;
        hold_req = HOLD_OFF_CYCLES;
        repeat (20) begin
            it = random_item();
            issue_command(it.cmd, it.addr, it.len, it.kind);
        end
        wait_drain();
    endtask

    // Receiver stall: long hold-off on request, else a mode that changes now and then
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 200);
                stall_pat = 8'($urandom);
            end
            mode_left--;
            case (stall_mode)
                STALL_OFF: i_stall <= 1'b0;
                STALL_RANDOM: i_stall <= ($urandom_range(0, 2) == 0);
                default: begin
                    stall_pat = {stall_pat[6:0], stall_pat[7]};
                    i_stall <= stall_pat[0];
                end
            endcase
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with none expected: status %0d, hit_addr %h",
                       o_status, o_hit_addr);
                fail_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_status !== oldest_result.status) begin
                    $error("status: expected %0d, got %0d", oldest_result.status, o_status);
                    fail_count++;
                end
                if (o_hit_addr !== oldest_result.hit_addr) begin
                    $error("hit_addr: expected %h, got %h", oldest_result.hit_addr,
                           o_hit_addr);
                    fail_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_commands();
        test_table_full();
        test_random_mix(470);
        test_backpressure();
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
hdl/bwt_pkg.sv
hdl/bwt_ram.sv
hdl/bwt_match.sv
hdl/breakpoint_watchpoint_table_top.sv
tb/tb_breakpoint_watchpoint_table_top.sv
